[sv/lpnal_pkg.sv]
// Shared types and constants for the length-prefixed NAL to start-code converter.
// No dependencies; imported by lpnal_conv, lpnal_emit and the top level.
package lpnal_pkg;

  localparam int unsigned DEF_MAX_PACKET_BYTES = 65536;

  localparam logic [2:0]  LenBytesMax = 3'd4;
  localparam logic [17:0] OutMax      = 18'h3FFFF;
  localparam logic [31:0] LenLimit    = 32'h7FFF_FFFB;

  // emitted in index order: 00 00 00 01
  localparam logic [3:0][7:0] StartCode = {8'h01, 8'h00, 8'h00, 8'h00};

  typedef enum logic [3:0] {
    PH_LEN   = 4'b0001,
    PH_PAY   = 4'b0010,
    PH_RAW   = 4'b0100,
    PH_DRAIN = 4'b1000
  } phase_e;

  // results caused by one input beat: n_data bytes, then optionally a verdict
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n_data;
    logic            verdict;
    logic            ok;
    logic [17:0]     size;
  } grp_t;

endpackage

[sv/lpnal_conv.sv]
// Packet parser: length-prefix tracking, payload countdown and verdict logic.
// Turns one input beat into a result group. Depends on lpnal_pkg.
module lpnal_conv #(
  parameter int unsigned MAX_PACKET_BYTES = lpnal_pkg::DEF_MAX_PACKET_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic [2:0]        field_cfg_i,
  output lpnal_pkg::grp_t   grp_o
);
  import lpnal_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 2);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_PACKET_BYTES);
  // payload lengths beyond this can never complete inside a legal packet
  localparam logic [31:0] PayCap = 32'(MAX_PACKET_BYTES + 1);

  phase_e           phase_q, phase_d;
  logic [31:0]      acc_q, acc_d;
  logic [2:0]       seen_q, seen_d;
  logic             first_q, first_d;
  logic [CNT_W-1:0] pay_q, pay_d;
  logic [17:0]      outcnt_q, outcnt_d;
  logic [2:0]       flen_q, flen_d;
  logic [CNT_W-1:0] incnt_q, incnt_d;

  always_comb begin
    phase_e           ph;
    logic [2:0]       fl;
    logic [2:0]       nd;
    logic [18:0]      sum;
    logic [31:0]      acc_n;
    logic [31:0]      aligned;
    logic [2:0]       seen_n;
    logic [CNT_W-1:0] pl_n;
    logic             start;
    logic             fin;
    logic             fin_ok;

    phase_d  = phase_q;
    acc_d    = acc_q;
    seen_d   = seen_q;
    first_d  = first_q;
    pay_d    = pay_q;
    incnt_d  = incnt_q;
    grp_o    = '0;
    nd       = '0;
    fin      = 1'b0;
    fin_ok   = 1'b0;

    start = (phase_q == PH_LEN) && first_q && (seen_q == '0) && (incnt_q == '0);
    fl = flen_q;
    ph = phase_q;
    if (start) begin
      fl = (field_cfg_i > LenBytesMax) ? LenBytesMax : field_cfg_i;
      if (fl == '0) ph = PH_RAW;
    end
    flen_d = fl;

    if (incnt_q <= MaxCnt) incnt_d = incnt_q + 1'b1;
    if (incnt_d > MaxCnt && ph != PH_DRAIN) ph = PH_DRAIN;

    acc_n   = {acc_q[23:0], byte_i};
    seen_n  = seen_q + 3'd1;
    // left-align the prefix bytes seen so far so byte 0 goes out first
    aligned = acc_n << {2'(3'd4 - seen_n), 3'b000};
    pl_n    = pay_q - 1'b1;

    unique case (ph)
      PH_RAW: begin
        nd             = 3'd1;
        grp_o.bytes[0] = byte_i;
        fin            = last_i;
        fin_ok         = 1'b1;
      end
      PH_LEN: begin
        acc_d  = acc_n;
        seen_d = seen_n;
        if (last_i) begin
          fin = 1'b1;
          if (first_q) begin
            // packet too short to hold a NAL unit: flush it raw
            nd     = seen_n;
            fin_ok = 1'b1;
            for (int j = 0; j < 4; j++) begin
              grp_o.bytes[j] = aligned[31-8*j -: 8];
            end
          end
        end else if (seen_n >= fl) begin
          if (acc_n == '0 || acc_n > LenLimit) begin
            ph = PH_DRAIN;
          end else begin
            nd          = 3'd4;
            grp_o.bytes = StartCode;
            pay_d       = (acc_n > PayCap) ? PayCap[CNT_W-1:0] : acc_n[CNT_W-1:0];
            acc_d       = '0;
            seen_d      = '0;
            first_d     = 1'b0;
            ph          = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        nd             = 3'd1;
        grp_o.bytes[0] = byte_i;
        pay_d          = pl_n;
        if (pl_n == '0) ph = PH_LEN;
        fin    = last_i;
        fin_ok = (pl_n == '0);
      end
      default: begin
        // draining after an error
        fin = last_i;
      end
    endcase

    phase_d = ph;
    sum      = {1'b0, outcnt_q} + 19'(nd);
    outcnt_d = (sum > {1'b0, OutMax}) ? OutMax : sum[17:0];

    grp_o.n_data  = nd;
    grp_o.verdict = fin;
    grp_o.ok      = fin_ok;
    grp_o.size    = outcnt_d;

    if (fin) begin
      phase_d  = PH_LEN;
      acc_d    = '0;
      seen_d   = '0;
      first_d  = 1'b1;
      pay_d    = '0;
      outcnt_d = '0;
      flen_d   = '0;
      incnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN;
      acc_q    <= '0;
      seen_q   <= '0;
      first_q  <= 1'b1;
      pay_q    <= '0;
      outcnt_q <= '0;
      flen_q   <= '0;
      incnt_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      first_q  <= first_d;
      pay_q    <= pay_d;
      outcnt_q <= outcnt_d;
      flen_q   <= flen_d;
      incnt_q  <= incnt_d;
    end
  end

endmodule

[sv/lpnal_emit.sv]
// Result register: holds one result group and sends it out one beat at a time.
// Depends on lpnal_pkg.
module lpnal_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  lpnal_pkg::grp_t grp_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            result_kind_o,
  output logic [7:0]      out_byte_o,
  output logic            packet_ok_o,
  output logic [17:0]     out_size_o,
  output logic            run_last_o
);
  import lpnal_pkg::*;

  logic            valid_q, valid_d;
  logic [3:0][7:0] bytes_q, bytes_d;
  logic [2:0]      nd_q, nd_d;
  logic            verdict_q, verdict_d;
  logic            ok_q, ok_d;
  logic [17:0]     size_q, size_d;
  logic            is_verdict;
  logic            tail;

  assign is_verdict = (nd_q == '0);
  assign tail       = is_verdict || (nd_q == 3'd1 && !verdict_q);
  assign free_o     = !valid_q || (out_ready_i && tail);

  always_comb begin
    valid_d   = valid_q;
    bytes_d   = bytes_q;
    nd_d      = nd_q;
    verdict_d = verdict_q;
    ok_d      = ok_q;
    size_d    = size_q;
    if (load_i) begin
      valid_d   = 1'b1;
      bytes_d   = grp_i.bytes;
      nd_d      = grp_i.n_data;
      verdict_d = grp_i.verdict;
      ok_d      = grp_i.ok;
      size_d    = grp_i.size;
    end else if (valid_q && out_ready_i) begin
      if (tail) begin
        valid_d = 1'b0;
      end else begin
        bytes_d = {8'h00, bytes_q[3:1]};
        nd_d    = nd_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q   <= bytes_d;
    nd_q      <= nd_d;
    verdict_q <= verdict_d;
    ok_q      <= ok_d;
    size_q    <= size_d;
  end

  assign out_valid_o   = valid_q;
  assign result_kind_o = is_verdict;
  assign out_byte_o    = is_verdict ? 8'h00 : bytes_q[0];
  assign packet_ok_o   = is_verdict & ok_q;
  assign out_size_o    = is_verdict ? size_q : 18'h0;
  assign run_last_o    = tail;

endmodule

[sv/length_prefixed_nal_to_start_codes.sv]
// Converts length-prefixed NAL units of one packet to start-code form.
// Top level; depends on lpnal_pkg, lpnal_conv and lpnal_emit.
//
// Bytes of one packet enter one per beat with a flag on the final byte. Each NAL
// length prefix (cfg size 1..4 bytes, sampled at the first byte of a packet; 0 =
// raw pass-through, 5..7 = 4) is replaced by 00 00 00 01 and payload bytes are
// copied. After the final byte a verdict beat (result_kind 1) carries packet_ok
// and the converted size; a packet with packet_ok 0 must be discarded, and no
// data follows an error inside it. Throughput is one input byte per cycle while
// each byte yields one result and out_ready_i is high; a byte that completes a
// length prefix yields four results and the final byte adds the verdict, so the
// input stalls while the extra results go out. The single output register, one
// result per cycle, sets that figure. Bytes pass the input and result registers.
module length_prefixed_nal_to_start_codes #(
  parameter int unsigned MAX_PACKET_BYTES = lpnal_pkg::DEF_MAX_PACKET_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        packet_ok_o,
  output logic [17:0] out_size_o,
  output logic        run_last_o
);
  import lpnal_pkg::*;

  logic [2:0] cfg_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       free;
  logic       step;
  logic       load;
  grp_t       grp;

  assign step       = s1_valid_q & free;
  assign in_ready_o = !s1_valid_q | free;
  assign load       = step & ((grp.n_data != '0) | grp.verdict);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= in_last_i;
    end
  end

  lpnal_conv #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (s1_byte_q),
    .last_i     (s1_last_q),
    .field_cfg_i(cfg_q),
    .grp_o      (grp)
  );

  lpnal_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .grp_i        (grp),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_kind_o(result_kind_o),
    .out_byte_o   (out_byte_o),
    .packet_ok_o  (packet_ok_o),
    .out_size_o   (out_size_o),
    .run_last_o   (run_last_o)
  );

endmodule
